[sv/keyfob_command_decoder_assert.svh]
// Assertion macros used by the keyfob command decoder top level.
`ifndef KEYFOB_COMMAND_DECODER_ASSERT_SVH
`define KEYFOB_COMMAND_DECODER_ASSERT_SVH

// Checks a condition that must hold in the same cycle as the trigger.
`define KCD_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("keyfob command decoder assertion failed");

// Checks a condition that must hold in the cycle after the trigger.
`define KCD_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("keyfob command decoder assertion failed");

`endif

[sv/kcd_pkg.sv]
// Package with types, register indexes and reset values of the keyfob command decoder.
package kcd_pkg;

   localparam int unsigned CodeWidth     = 32;
   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned WindowWidth   = 16;
   localparam int unsigned ClickWidth    = 2;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [CodeWidth-1:0]   LockCodeReset     = 32'd4933471;
   localparam logic [CodeWidth-1:0]   UnlockCodeReset   = 32'd4933468;
   localparam logic [CodeWidth-1:0]   TrunkCodeReset    = 32'd4933464;
   localparam logic [CodeWidth-1:0]   SearchCodeReset   = 32'd0;
   localparam logic [WindowWidth-1:0] DebounceReset     = 16'd200;
   localparam logic [WindowWidth-1:0] ClickTimeoutReset = 16'd600;
   localparam logic [TimeWidth-1:0]   LightOnReset      = 32'd15000;

   localparam logic [ClickWidth-1:0]  ToggleClicks      = 2'd3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LOCK_CODE,
      CSR_UNLOCK_CODE,
      CSR_TRUNK_CODE,
      CSR_SEARCH_CODE,
      CSR_DEBOUNCE_WINDOW,
      CSR_CLICK_TIMEOUT,
      CSR_LIGHT_ON
   } csr_index_type;

   typedef struct packed {
      logic [CodeWidth-1:0]   lock_code;
      logic [CodeWidth-1:0]   unlock_code;
      logic [CodeWidth-1:0]   trunk_code;
      logic [CodeWidth-1:0]   search_code;
      logic [WindowWidth-1:0] debounce_window_ms;
      logic [WindowWidth-1:0] click_timeout_ms;
      logic [TimeWidth-1:0]   light_on_ms;
   } cfg_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 code_valid;
      logic [CodeWidth-1:0] rx_code;
   } req_type;

   typedef struct packed {
      logic light_on;
      logic arm_event;
      logic disarm_event;
      logic handsfree_toggle;
      logic trunk_event;
      logic hazard_request;
      logic unknown_code;
   } rsp_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  last_accept_time;
      logic                  light_active;
      logic [TimeWidth-1:0]  light_start_time;
      logic [ClickWidth-1:0] click_count;
      logic [TimeWidth-1:0]  last_click_time;
   } state_type;

endpackage

[sv/kcd_req_if.sv]
// Input channel carrying the timestamp and an optional received code.
interface kcd_req_if
   import kcd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [TimeWidth-1:0] now_ms;
   logic                 code_valid;
   logic [CodeWidth-1:0] rx_code;

   modport source (output valid, now_ms, code_valid, rx_code, input ready);
   modport sink (input valid, now_ms, code_valid, rx_code, output ready);
endinterface

[sv/kcd_rsp_if.sv]
// Result channel carrying the light level and the decoded events.
interface kcd_rsp_if;
   logic valid;
   logic ready;
   logic light_on;
   logic arm_event;
   logic disarm_event;
   logic handsfree_toggle;
   logic trunk_event;
   logic hazard_request;
   logic unknown_code;

   modport source (output valid, light_on, arm_event, disarm_event, handsfree_toggle,
                   trunk_event, hazard_request, unknown_code, input ready);
   modport sink (input valid, light_on, arm_event, disarm_event, handsfree_toggle,
                 trunk_event, hazard_request, unknown_code, output ready);
endinterface

[sv/kcd_csr_if.sv]
// Configuration write channel carrying a register index and write data.
interface kcd_csr_if
   import kcd_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/kcd_csr_regs.sv]
// Configuration register bank with button codes and timing windows.
module kcd_csr_regs
   import kcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CsrIndexWidth-1:0] wr_index,
   input  logic [CsrDataWidth-1:0]  wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_LOCK_CODE:       cfg_in.lock_code          = wr_data;
            CSR_UNLOCK_CODE:     cfg_in.unlock_code        = wr_data;
            CSR_TRUNK_CODE:      cfg_in.trunk_code         = wr_data;
            CSR_SEARCH_CODE:     cfg_in.search_code        = wr_data;
            CSR_DEBOUNCE_WINDOW: cfg_in.debounce_window_ms = wr_data[WindowWidth-1:0];
            CSR_CLICK_TIMEOUT:   cfg_in.click_timeout_ms   = wr_data[WindowWidth-1:0];
            CSR_LIGHT_ON:        cfg_in.light_on_ms        = wr_data;
            default:             cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lock_code          <= LockCodeReset;
         cfg_ff.unlock_code        <= UnlockCodeReset;
         cfg_ff.trunk_code         <= TrunkCodeReset;
         cfg_ff.search_code        <= SearchCodeReset;
         cfg_ff.debounce_window_ms <= DebounceReset;
         cfg_ff.click_timeout_ms   <= ClickTimeoutReset;
         cfg_ff.light_on_ms        <= LightOnReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/kcd_step.sv]
// Next-state and result logic for one timestamp beat: light timer, click run and code match.
module kcd_step
   import kcd_pkg::*;
(
   input  state_type state,
   input  req_type   item,
   input  cfg_type   cfg,
   output state_type state_next,
   output rsp_type   result
);

   logic [TimeWidth-1:0]  light_elapsed;
   logic [TimeWidth-1:0]  click_elapsed;
   logic [TimeWidth-1:0]  accept_elapsed;
   logic                  code_taken;
   logic [ClickWidth-1:0] clicks_plus;

   assign light_elapsed  = item.now_ms - state.light_start_time;
   assign click_elapsed  = item.now_ms - state.last_click_time;
   assign accept_elapsed = item.now_ms - state.last_accept_time;

   assign code_taken = item.code_valid && (item.rx_code != '0) &&
      (accept_elapsed > {{(TimeWidth-WindowWidth){1'b0}}, cfg.debounce_window_ms});

   always_comb begin
      state_next = state;
      result     = '0;

      if (state.light_active && (light_elapsed >= cfg.light_on_ms)) begin
         state_next.light_active = 1'b0;
      end

      if ((state.click_count != '0) &&
          (click_elapsed > {{(TimeWidth-WindowWidth){1'b0}}, cfg.click_timeout_ms})) begin
         if (state.click_count < ToggleClicks) begin
            result.arm_event            = 1'b1;
            state_next.light_active     = 1'b1;
            state_next.light_start_time = item.now_ms;
         end
         state_next.click_count = '0;
      end

      clicks_plus = state_next.click_count + 1'b1;

      if (code_taken) begin
         state_next.last_accept_time = item.now_ms;
         priority if (item.rx_code == cfg.lock_code) begin
            state_next.last_click_time = item.now_ms;
            if (clicks_plus == ToggleClicks) begin
               result.handsfree_toggle = 1'b1;
               state_next.click_count  = '0;
            end else begin
               state_next.click_count  = clicks_plus;
            end
         end else if (item.rx_code == cfg.unlock_code) begin
            state_next.click_count  = '0;
            state_next.light_active = 1'b0;
            result.disarm_event     = 1'b1;
         end else if (item.rx_code == cfg.trunk_code) begin
            state_next.click_count = '0;
            result.trunk_event     = 1'b1;
         end else if ((cfg.search_code != '0) && (item.rx_code == cfg.search_code)) begin
            state_next.click_count = '0;
            result.hazard_request  = 1'b1;
         end else begin
            result.unknown_code = 1'b1;
         end
      end

      result.light_on = state_next.light_active;
   end

endmodule

[sv/keyfob_command_decoder.sv]
// Top level of the keyfob command decoder: input register, decode step and result register.
// The decode step is the only logic between the input register and the result register.
// Throughput is one beat per cycle while the output is not stalled.
// A new request beat is taken while a finished response still waits on the output.
// Synchronous reset loads the register defaults and clears the light, click run and timestamps.
`include "keyfob_command_decoder_assert.svh"

module keyfob_command_decoder
   import kcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kcd_req_if.sink    req_ch,
   kcd_rsp_if.source  rsp_ch,
   kcd_csr_if.sink    csr_ch
);

   cfg_type   cfg;
   req_type   req_ff;
   req_type   req_in;
   logic      req_valid_ff;
   logic      req_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   state_type state_ff;
   state_type state_in;
   state_type state_next;
   rsp_type   step_result;
   logic      advance;
   logic      req_take;
   logic [4:0] rsp_buttons;

   assign csr_ch.ready = 1'b1;

   kcd_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid && csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   kcd_step u_step (
      .state      (state_ff),
      .item       (req_ff),
      .cfg        (cfg),
      .state_next (state_next),
      .result     (step_result)
   );

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      req_in.now_ms     = req_ch.now_ms;
      req_in.code_valid = req_ch.code_valid;
      req_in.rx_code    = req_ch.rx_code;

      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_result;
         state_in     = state_next;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
         rsp_in       = rsp_ff;
         state_in     = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.light_on         = rsp_ff.light_on;
   assign rsp_ch.arm_event        = rsp_ff.arm_event;
   assign rsp_ch.disarm_event     = rsp_ff.disarm_event;
   assign rsp_ch.handsfree_toggle = rsp_ff.handsfree_toggle;
   assign rsp_ch.trunk_event      = rsp_ff.trunk_event;
   assign rsp_ch.hazard_request   = rsp_ff.hazard_request;
   assign rsp_ch.unknown_code     = rsp_ff.unknown_code;

   assign rsp_buttons = {rsp_ff.disarm_event, rsp_ff.handsfree_toggle, rsp_ff.trunk_event,
                         rsp_ff.hazard_request, rsp_ff.unknown_code};

   // A taken code matches at most one button, and an unlock always leaves the light off.
   `KCD_ASSERT_NOW(a_one_button, rsp_valid_ff, $onehot0(rsp_buttons))
   `KCD_ASSERT_NOW(a_disarm_dark, rsp_valid_ff && rsp_ff.disarm_event, !rsp_ff.light_on)
   `KCD_ASSERT_NOW(a_arm_lights, rsp_valid_ff && rsp_ff.arm_event && !rsp_ff.disarm_event, rsp_ff.light_on)
   `KCD_ASSERT_NEXT(a_state_holds, !advance, state_ff == $past(state_ff))

endmodule

[tb/tb_keyfob_command_decoder.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the keyfob command decoder with directed rows and random phases.
module tb_keyfob_command_decoder;
   import kcd_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 3'd7;
   localparam rsp_type NO_EVENT     = '0;
   localparam rsp_type UNKNOWN_ONLY = '{unknown_code: 1'b1, default: 1'b0};
   localparam int RandomPhases   = 8;
   localparam int ItemsPerPhase  = 125;
   localparam int LongHoldCycles = 150;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kcd_req_if req_ch();
   kcd_rsp_if rsp_ch();
   kcd_csr_if csr_ch();

   keyfob_command_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfg_type              fob_cfg;
   state_type            fob_state;
   rsp_type              expected_rsp_q[$];
   dir_row_type          dir_rows[$];
   int unsigned          mismatch_count = 0;
   bit                   tx_idle_on = 1'b1;
   bit                   rx_idle_on = 1'b1;
   bit                   hold_pending = 1'b0;
   logic [TimeWidth-1:0] fob_time = '0;

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic rsp_type decode_keyfob_step(req_type beat);
      rsp_type              r;
      logic [TimeWidth-1:0] since_light;
      logic [TimeWidth-1:0] since_click;
      logic [TimeWidth-1:0] since_accept;
      r = NO_EVENT;
      since_light = beat.now_ms - fob_state.light_start_time;
      if (fob_state.light_active && since_light >= fob_cfg.light_on_ms) begin
         fob_state.light_active = 1'b0;
      end
      since_click = beat.now_ms - fob_state.last_click_time;
      if (fob_state.click_count != '0 && since_click > {16'b0, fob_cfg.click_timeout_ms}) begin
         if (fob_state.click_count < ToggleClicks) begin
            r.arm_event = 1'b1;
            fob_state.light_active = 1'b1;
            fob_state.light_start_time = beat.now_ms;
         end
         fob_state.click_count = '0;
      end
      since_accept = beat.now_ms - fob_state.last_accept_time;
      if (beat.code_valid && beat.rx_code != '0
          && since_accept > {16'b0, fob_cfg.debounce_window_ms}) begin
         fob_state.last_accept_time = beat.now_ms;
         if (beat.rx_code == fob_cfg.lock_code) begin
            fob_state.click_count = fob_state.click_count + 1'b1;
            fob_state.last_click_time = beat.now_ms;
            if (fob_state.click_count == ToggleClicks) begin
               r.handsfree_toggle = 1'b1;
               fob_state.click_count = '0;
            end
         end else if (beat.rx_code == fob_cfg.unlock_code) begin
            fob_state.click_count = '0;
            r.disarm_event = 1'b1;
            fob_state.light_active = 1'b0;
         end else if (beat.rx_code == fob_cfg.trunk_code) begin
            fob_state.click_count = '0;
            r.trunk_event = 1'b1;
         end else if (fob_cfg.search_code != '0 && beat.rx_code == fob_cfg.search_code) begin
            fob_state.click_count = '0;
            r.hazard_request = 1'b1;
         end else begin
            r.unknown_code = 1'b1;
         end
      end
      r.light_on = fob_state.light_active;
      return r;
   endfunction

   function automatic int unsigned pick_gap(bit on);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!on || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_row(logic [TimeWidth-1:0] now, logic valid,
                                   logic [CodeWidth-1:0] code, bit typed, rsp_type want);
      dir_row_type row;
      row.beat.now_ms = now;
      row.beat.code_valid = valid;
      row.beat.rx_code = code;
      row.typed = typed;
      row.want = want;
      dir_rows.push_back(row);
   endfunction

   function automatic req_type random_beat();
      req_type              beat;
      logic [TimeWidth-1:0] step;
      int unsigned          roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) step = $urandom_range(0, 60);
      else if (roll < 45) step = fob_cfg.debounce_window_ms + $urandom_range(0, 4) - 2;
      else if (roll < 65) step = fob_cfg.click_timeout_ms + $urandom_range(0, 4) - 2;
      else if (roll < 75) step = fob_cfg.light_on_ms + $urandom_range(0, 4) - 2;
      else if (roll < 92) step = $urandom_range(0, 2000);
      else step = $urandom();
      fob_time = fob_time + step;
      beat.now_ms = fob_time;
      beat.code_valid = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 35) beat.rx_code = fob_cfg.lock_code;
      else if (roll < 47) beat.rx_code = fob_cfg.unlock_code;
      else if (roll < 57) beat.rx_code = fob_cfg.trunk_code;
      else if (roll < 63) beat.rx_code = fob_cfg.search_code;
      else if (roll < 75) beat.rx_code = $urandom();
      else if (roll < 82) beat.rx_code = '0;
      else begin
         beat.code_valid = 1'b0;
         beat.rx_code = $urandom();
      end
      return beat;
   endfunction

   task automatic send_beat(req_type beat, bit typed, rsp_type want);
      rsp_type predicted;
      repeat (pick_gap(tx_idle_on)) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.now_ms = beat.now_ms;
      req_ch.code_valid = beat.code_valid;
      req_ch.rx_code = beat.rx_code;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = decode_keyfob_step(beat);
      expected_rsp_q.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (index)
         CSR_LOCK_CODE:       fob_cfg.lock_code = data;
         CSR_UNLOCK_CODE:     fob_cfg.unlock_code = data;
         CSR_TRUNK_CODE:      fob_cfg.trunk_code = data;
         CSR_SEARCH_CODE:     fob_cfg.search_code = data;
         CSR_DEBOUNCE_WINDOW: fob_cfg.debounce_window_ms = data[WindowWidth-1:0];
         CSR_CLICK_TIMEOUT:   fob_cfg.click_timeout_ms = data[WindowWidth-1:0];
         CSR_LIGHT_ON:        fob_cfg.light_on_ms = data;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic choose_settings(int phase);
      logic [CodeWidth-1:0]   lock;
      logic [WindowWidth-1:0] junk;
      logic [WindowWidth-1:0] debounce;
      logic [WindowWidth-1:0] timeout;
      logic [TimeWidth-1:0]   light;
      lock = $urandom();
      junk = $urandom();
      debounce = $urandom_range(0, 400);
      timeout = $urandom_range(0, 1000);
      light = $urandom_range(0, 3000);
      if (phase == 1) begin
         debounce = '0;
         timeout = '0;
         light = '0;
      end else if (phase == 2) begin
         debounce = '1;
         timeout = '1;
         light = '1;
      end
      if (phase == 0) write_setting(CSR_UNUSED, $urandom());
      write_setting(CSR_LOCK_CODE, lock);
      write_setting(CSR_UNLOCK_CODE, phase == 5 ? lock : $urandom());
      write_setting(CSR_TRUNK_CODE, phase == 5 ? lock : $urandom());
      if (phase == 5) write_setting(CSR_SEARCH_CODE, lock);
      else if (phase % 3 == 0) write_setting(CSR_SEARCH_CODE, '0);
      else write_setting(CSR_SEARCH_CODE, $urandom());
      write_setting(CSR_DEBOUNCE_WINDOW, {junk, debounce});
      write_setting(CSR_CLICK_TIMEOUT, {~junk, timeout});
      write_setting(CSR_LIGHT_ON, light);
   endtask

   function automatic void check_bit(string field, logic want, logic seen);
      if (want !== seen) begin
         $display("%0t: %s expected %b, actual %b", $time, field, want, seen);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = '{light_on: rsp_ch.light_on, arm_event: rsp_ch.arm_event,
                  disarm_event: rsp_ch.disarm_event, handsfree_toggle: rsp_ch.handsfree_toggle,
                  trunk_event: rsp_ch.trunk_event, hazard_request: rsp_ch.hazard_request,
                  unknown_code: rsp_ch.unknown_code};
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: result beat expected none, actual %b", $time, seen);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_bit("light_on", want.light_on, seen.light_on);
            check_bit("arm_event", want.arm_event, seen.arm_event);
            check_bit("disarm_event", want.disarm_event, seen.disarm_event);
            check_bit("handsfree_toggle", want.handsfree_toggle, seen.handsfree_toggle);
            check_bit("trunk_event", want.trunk_event, seen.trunk_event);
            check_bit("hazard_request", want.hazard_request, seen.hazard_request);
            check_bit("unknown_code", want.unknown_code, seen.unknown_code);
         end
      end
   end

   // The receiver stalls on its own count; a long hold-off lets the block back up into the input.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left = LongHoldCycles;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            stall_left = pick_gap(rx_idle_on);
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.now_ms = '0;
      req_ch.code_valid = 1'b0;
      req_ch.rx_code = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      fob_cfg = '{lock_code: LockCodeReset, unlock_code: UnlockCodeReset,
                  trunk_code: TrunkCodeReset, search_code: SearchCodeReset,
                  debounce_window_ms: DebounceReset, click_timeout_ms: ClickTimeoutReset,
                  light_on_ms: LightOnReset};
      fob_state = '0;

      // Codes close to time zero fall inside the debounce window right after reset.
      add_row(32'd0, 1'b1, LockCodeReset, 1'b1, NO_EVENT);
      add_row(32'd150, 1'b1, UnlockCodeReset, 1'b1, NO_EVENT);
      add_row(32'd1000, 1'b0, LockCodeReset, 1'b1, NO_EVENT);
      add_row(32'd1000, 1'b1, 32'd0, 1'b1, NO_EVENT);
      add_row(32'd1000, 1'b1, 32'hFFFF_FFFF, 1'b1, UNKNOWN_ONLY);
      add_row(32'd1200, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd1201, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd1500, 1'b1, 32'h5A5A_A5A5, 1'b0, NO_EVENT);
      add_row(32'd1802, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'd2100, 1'b1, UnlockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd2400, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd2700, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd3000, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd3300, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd3600, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'd4300, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'd4600, 1'b1, TrunkCodeReset, 1'b0, NO_EVENT);
      add_row(32'd19299, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'd19300, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'hFFFF_FF00, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'h0000_0100, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'h0000_025A, 1'b0, 32'd0, 1'b0, NO_EVENT);
      add_row(32'h0000_0300, 1'b1, LockCodeReset, 1'b0, NO_EVENT);
      add_row(32'h0000_0400, 1'b1, UnlockCodeReset, 1'b0, NO_EVENT);
      add_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, NO_EVENT);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_drained();
         choose_settings(phase);
         tx_idle_on = $urandom_range(0, 3) != 0;
         rx_idle_on = $urandom_range(0, 3) != 0;
         if (phase == 3) begin
            tx_idle_on = 1'b0;
            hold_pending = 1'b1;
         end
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_beat(random_beat(), 1'b0, NO_EVENT);
            if (phase == 6 && n == ItemsPerPhase / 2) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/kcd_pkg.sv
sv/kcd_req_if.sv
sv/kcd_rsp_if.sv
sv/kcd_csr_if.sv
sv/kcd_csr_regs.sv
sv/kcd_step.sv
sv/keyfob_command_decoder.sv
tb/tb_keyfob_command_decoder.sv
